### hw/rtl/twbsm_pkg.sv
// Shared constants and types for the two-wire bit-serial master.
package twbsm_pkg;

    localparam int PERIOD        = 42;
    localparam int BITS_PER_BYTE = 8;
    localparam int PERIOD_W      = $clog2(PERIOD);
    localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
    localparam int PRESCALE_W    = 16;
    localparam int KIND_W        = 4;
    localparam int CFG_DATA_W    = 16;

    // Command codes
    localparam logic [KIND_W-1:0] KIND_WRITE_BYTE = 4'd0;
    localparam logic [KIND_W-1:0] KIND_READ_BYTE  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_CLK_HIGH   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_CLK_LOW    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_CLK_PULSE  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SDA_HIGH   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_SDA_LOW    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_READ_CLKD  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_READ_BIT   = 4'd8;

    // Configuration register indexes
    localparam logic REG_LSB_FIRST     = 1'b0;
    localparam logic REG_TICK_PRESCALE = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    // One pin event as decoded from the current step
    typedef struct packed {
        logic       is_edge;
        logic       clk_pin;
        logic       sda_latch;
        logic       sda_drive;
        logic [7:0] rx;
        logic       last;
    } event_t;

endpackage

### hw/rtl/two_wire_bit_serial_master.sv
// Two-wire bit-serial master: command sequencer, tick timer and result register.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_data
//   in       in         in_valid / in_ready  kind, tx_byte, line_bits
//   out      out        out_valid / out_ready clk_level, sda_level, sda_drive, rx_value, last
//
// Every clock edge waits for the tick, which the timer raises anew after the previous edge or
// prescale write, so a byte waits for the tick at each clock edge. The data-set beats of a write
// byte overlap the waits, all but the first. The first edge after a long idle goes at once.
// One command is in work at a time; in_ready is high only when the sequencer is idle.
// A stalled out channel holds the sequencer.
// Reset: clock pin low, data latch low, data driver on, tick timer cleared.
module two_wire_bit_serial_master
    import twbsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [KIND_W-1:0]     kind,
    input  logic [7:0]            tx_byte,
    input  logic [7:0]            line_bits,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  clk_level,
    output logic                  sda_level,
    output logic                  sda_drive,
    output logic [7:0]            rx_value,
    output logic                  last
);

    state_t                 state_reg, state_next;
    logic                   lsb_first_reg;
    logic [PRESCALE_W-1:0]  tick_prescale_reg;
    logic [PRESCALE_W-1:0]  prescale_cnt_reg;
    logic [PERIOD_W-1:0]    period_cnt_reg;
    logic                   tick_pending_reg;

    logic                   clk_pin_reg;
    logic                   sda_latch_reg;
    logic                   sda_drive_reg;

    logic [KIND_W-1:0]      kind_reg;
    logic [7:0]             tx_sr_reg;
    logic [7:0]             line_sr_reg;
    logic [7:0]             rx_sr_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [1:0]             phase_reg;

    logic                   out_valid_reg;
    event_t                 out_evt_reg;

    event_t                 evt;
    logic                   in_fire;
    logic                   can_emit;
    logic                   fire;
    logic                   tx_bit;
    logic                   bit_done;
    logic [7:0]             rx_shifted;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign can_emit  = !out_valid_reg || out_ready;
    assign fire      = (state_reg == ST_BUSY) && can_emit && (!evt.is_edge || tick_pending_reg);
    assign tx_bit    = lsb_first_reg ? tx_sr_reg[0] : tx_sr_reg[7];
    assign bit_done  = (bit_cnt_reg == BIT_CNT_W'(BITS_PER_BYTE - 1));
    assign rx_shifted = lsb_first_reg ? {line_sr_reg[0], rx_sr_reg[7:1]}
                                      : {rx_sr_reg[6:0], line_sr_reg[0]};

    // Decode the pin event of the current step
    always_comb
    begin
        evt           = '0;
        evt.clk_pin   = clk_pin_reg;
        evt.sda_latch = sda_latch_reg;
        evt.sda_drive = sda_drive_reg;
        unique case (kind_reg)
            KIND_WRITE_BYTE:
            begin
                evt.sda_drive = 1'b1;
                if (phase_reg == 2'd0)
                begin
                    evt.sda_latch = tx_bit;
                end
                else
                begin
                    evt.is_edge = 1'b1;
                    evt.clk_pin = (phase_reg == 2'd1);
                    evt.last    = (phase_reg == 2'd2) && bit_done;
                end
            end
            KIND_READ_BYTE:
            begin
                evt.sda_drive = 1'b0;
                evt.is_edge   = 1'b1;
                evt.clk_pin   = (phase_reg == 2'd0);
                evt.last      = (phase_reg != 2'd0) && bit_done;
                evt.rx        = evt.last ? rx_shifted : 8'd0;
            end
            KIND_CLK_HIGH:
            begin
                evt.is_edge = 1'b1;
                evt.clk_pin = 1'b1;
                evt.last    = 1'b1;
            end
            KIND_CLK_LOW:
            begin
                evt.is_edge = 1'b1;
                evt.clk_pin = 1'b0;
                evt.last    = 1'b1;
            end
            KIND_CLK_PULSE:
            begin
                evt.is_edge = 1'b1;
                evt.clk_pin = (phase_reg == 2'd0);
                evt.last    = (phase_reg != 2'd0);
            end
            KIND_SDA_HIGH:
            begin
                evt.sda_latch = 1'b1;
                evt.last      = 1'b1;
            end
            KIND_SDA_LOW:
            begin
                evt.sda_latch = 1'b0;
                evt.last      = 1'b1;
            end
            KIND_READ_CLKD:
            begin
                evt.is_edge = 1'b1;
                evt.clk_pin = (phase_reg == 2'd0);
                evt.last    = (phase_reg != 2'd0);
                evt.rx      = evt.last ? {7'd0, line_sr_reg[0]} : 8'd0;
            end
            KIND_READ_BIT:
            begin
                evt.last = 1'b1;
                evt.rx   = {7'd0, line_sr_reg[0]};
            end
            default:
            begin
                evt.last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (kind <= KIND_READ_BIT))
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (fire && evt.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            lsb_first_reg     <= 1'b0;
            tick_prescale_reg <= '0;
            prescale_cnt_reg  <= '0;
            period_cnt_reg    <= '0;
            tick_pending_reg  <= 1'b0;
            clk_pin_reg       <= 1'b0;
            sda_latch_reg     <= 1'b0;
            sda_drive_reg     <= 1'b1;
            out_valid_reg     <= 1'b0;
            phase_reg         <= '0;
            bit_cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Free-running tick timer; an edge or a prescale write restarts it
            if ((cfg_we && (cfg_index == REG_TICK_PRESCALE)) || (fire && evt.is_edge))
            begin
                prescale_cnt_reg <= '0;
                period_cnt_reg   <= '0;
                tick_pending_reg <= 1'b0;
            end
            else if (period_cnt_reg == PERIOD_W'(PERIOD - 1))
            begin
                period_cnt_reg <= '0;
                if (prescale_cnt_reg == tick_prescale_reg)
                begin
                    prescale_cnt_reg <= '0;
                    tick_pending_reg <= 1'b1;
                end
                else
                begin
                    prescale_cnt_reg <= prescale_cnt_reg + 1'b1;
                end
            end
            else
            begin
                period_cnt_reg <= period_cnt_reg + 1'b1;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LSB_FIRST:     lsb_first_reg     <= cfg_data[0];
                    REG_TICK_PRESCALE: tick_prescale_reg <= cfg_data[PRESCALE_W-1:0];
                endcase
            end

            if (in_fire)
            begin
                phase_reg   <= '0;
                bit_cnt_reg <= '0;
            end
            else if (fire)
            begin
                clk_pin_reg   <= evt.clk_pin;
                sda_latch_reg <= evt.sda_latch;
                sda_drive_reg <= evt.sda_drive;
                if ((kind_reg == KIND_WRITE_BYTE) && (phase_reg == 2'd2))
                begin
                    phase_reg   <= '0;
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                end
                else if ((kind_reg == KIND_READ_BYTE) && (phase_reg == 2'd1))
                begin
                    phase_reg   <= '0;
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                end
                else
                begin
                    phase_reg <= phase_reg + 1'b1;
                end
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: command shift registers and result beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg    <= kind;
            tx_sr_reg   <= tx_byte;
            line_sr_reg <= line_bits;
            rx_sr_reg   <= '0;
        end
        else if (fire)
        begin
            if ((kind_reg == KIND_WRITE_BYTE) && (phase_reg == 2'd0))
            begin
                tx_sr_reg <= lsb_first_reg ? {1'b0, tx_sr_reg[7:1]} : {tx_sr_reg[6:0], 1'b0};
            end
            // Sample after the falling edge
            if ((kind_reg == KIND_READ_BYTE) && (phase_reg == 2'd1))
            begin
                rx_sr_reg   <= rx_shifted;
                line_sr_reg <= {1'b0, line_sr_reg[7:1]};
            end
        end
        if (fire)
        begin
            out_evt_reg <= evt;
        end
    end

    assign out_valid = out_valid_reg;
    assign clk_level = out_evt_reg.clk_pin;
    assign sda_level = out_evt_reg.sda_latch;
    assign sda_drive = out_evt_reg.sda_drive;
    assign rx_value  = out_evt_reg.rx;
    assign last      = out_evt_reg.last;

endmodule

### hw/rtl/twbsm_checker.sv
// Port-level checks for the two-wire bit-serial master, bound to the top level.
module twbsm_checker
    import twbsm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [KIND_W-1:0] kind,
    input logic              out_valid,
    input logic              out_ready,
    input logic              clk_level,
    input logic              sda_level,
    input logic              sda_drive,
    input logic [7:0]        rx_value,
    input logic              last
);

    // A real command blocks new input until its last beat is produced
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind <= KIND_READ_BIT)) |=> !in_ready)
        else $error("input accepted twice without finishing a command");

    // Read data is only shown on the last beat
    a_rx_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (rx_value == 8'd0))
        else $error("rx_value nonzero on a non-final beat");

    // Sequencer only returns to idle after a last beat is produced
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(in_ready) && $past(rst_n)) |-> (out_valid && last))
        else $error("command ended without a last beat");

    // Stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(clk_level) && $stable(sda_level)
                                       && $stable(sda_drive) && $stable(rx_value)
                                       && $stable(last)))
        else $error("output beat changed while stalled");

endmodule

bind two_wire_bit_serial_master twbsm_checker u_twbsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .clk_level (clk_level),
    .sda_level (sda_level),
    .sda_drive (sda_drive),
    .rx_value  (rx_value),
    .last      (last)
);

### tb/two_wire_bit_serial_master_test.sv
// Self-checking testbench for the two-wire bit-serial master: command beats in, pin events out.
`timescale 1ns / 1ps

module two_wire_bit_serial_master_test;
    import twbsm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 4'd9;
    localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 4'd15;
    localparam int                SETTLE_CYCLES     = 2 * PERIOD;
    localparam int                CYCLE_LIMIT       = 2_000_000;
    localparam int                NUM_PHASES        = 5;

    // test phases: bit order, prescaler, command count
    localparam int PHASE_LSB [NUM_PHASES]      = '{1, 0, 1, 0, 1};
    localparam int PHASE_PRESCALE [NUM_PHASES] = '{0, 1, 65535, 3, 0};
    localparam int PHASE_ITEMS [NUM_PHASES]    = '{35, 30, 15, 20, 35};

    typedef struct packed {
        logic       clk_pin;
        logic       sda;
        logic       drive;
        logic [7:0] rx;
        logic       fin;
    } pin_event_t;

    typedef struct packed {
        logic [KIND_W-1:0] k;
        logic [7:0]        tx;
        logic [7:0]        line;
        logic              typed;
        pin_event_t        golden;
    } cmd_row_t;

    localparam pin_event_t NO_GOLDEN = '0;
    localparam int         NUM_ROWS  = 24;

    // typed final beat where it is obvious; the rest goes through the predictor
    localparam cmd_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{KIND_READ_BIT,   8'h00, 8'h01, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h01, 1'b1}},
        '{KIND_READ_BIT,   8'hFF, 8'hFE, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h00, 1'b1}},
        '{KIND_FIRST_UNUSED, 8'hFF, 8'hFF, 1'b0, NO_GOLDEN},
        '{KIND_LAST_UNUSED,  8'h00, 8'h00, 1'b0, NO_GOLDEN},
        '{KIND_CLK_LOW,    8'h12, 8'h34, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h00, 1'b1}},
        '{KIND_CLK_HIGH,   8'h00, 8'hFF, 1'b1, '{1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
        '{KIND_CLK_HIGH,   8'hFF, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
        '{KIND_CLK_PULSE,  8'h55, 8'hAA, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h00, 1'b1}},
        '{KIND_SDA_HIGH,   8'h00, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b1, 8'h00, 1'b1}},
        '{KIND_SDA_LOW,    8'hFF, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h00, 1'b1}},
        '{KIND_WRITE_BYTE, 8'hFF, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b1, 8'h00, 1'b1}},
        '{KIND_WRITE_BYTE, 8'h00, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h00, 1'b1}},
        '{KIND_WRITE_BYTE, 8'hA5, 8'h0F, 1'b0, NO_GOLDEN},
        '{KIND_READ_BYTE,  8'h00, 8'hFF, 1'b1, '{1'b0, 1'b1, 1'b0, 8'hFF, 1'b1}},
        '{KIND_READ_BYTE,  8'hFF, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00, 1'b1}},
        '{KIND_READ_BYTE,  8'h00, 8'h01, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h80, 1'b1}},
        '{KIND_SDA_HIGH,   8'h00, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00, 1'b1}},
        '{KIND_SDA_LOW,    8'h00, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b1}},
        '{KIND_READ_BIT,   8'h00, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h01, 1'b1}},
        '{KIND_READ_CLKD,  8'h00, 8'h01, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h01, 1'b1}},
        '{KIND_READ_CLKD,  8'hFF, 8'hFE, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b1}},
        '{KIND_WRITE_BYTE, 8'h3C, 8'hC3, 1'b0, NO_GOLDEN},
        '{KIND_FIRST_UNUSED + 4'd3, 8'h81, 8'h18, 1'b0, NO_GOLDEN},
        '{KIND_READ_BYTE,  8'h99, 8'h5A, 1'b0, NO_GOLDEN}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [KIND_W-1:0]     kind;
    logic [7:0]            tx_byte;
    logic [7:0]            line_bits;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  clk_level;
    logic                  sda_level;
    logic                  sda_drive;
    logic [7:0]            rx_value;
    logic                  last;

    // side band that travels with each command beat
    logic       golden_on;
    pin_event_t golden_ev;
    logic       no_idle;

    // predictor state
    logic order_lsb = 1'b0;
    logic pin_clk   = 1'b0;
    logic pin_sda   = 1'b0;
    logic pin_drive = 1'b1;

    pin_event_t pending_events [$];
    int         mismatches = 0;
    int         cycles     = 0;
    int         hold_left  = 0;

    two_wire_bit_serial_master DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .tx_byte   (tx_byte),
        .line_bits (line_bits),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .clk_level (clk_level),
        .sda_level (sda_level),
        .sda_drive (sda_drive),
        .rx_value  (rx_value),
        .last      (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void push_pin_event(input logic [7:0] rx, input logic fin);
        pending_events.push_back('{pin_clk, pin_sda, pin_drive, rx, fin});
    endfunction

    // Pin events one command causes, in order; pacing is not modeled.
    function automatic void predict_pin_events(input logic [KIND_W-1:0] k,
                                               input logic [7:0] tx,
                                               input logic [7:0] line);
        logic [BIT_CNT_W-1:0] pos;
        logic [7:0]           assembled;
        assembled = '0;
        case (k)
            KIND_WRITE_BYTE:
            begin
                pin_drive = 1'b1;
                for (int i = 0; i < BITS_PER_BYTE; i++)
                begin
                    pos = BIT_CNT_W'(order_lsb ? i : BITS_PER_BYTE - 1 - i);
                    pin_sda = tx[pos];
                    push_pin_event(8'h00, 1'b0);
                    pin_clk = 1'b1;
                    push_pin_event(8'h00, 1'b0);
                    pin_clk = 1'b0;
                    push_pin_event(8'h00, i == BITS_PER_BYTE - 1);
                end
            end
            KIND_READ_BYTE:
            begin
                pin_drive = 1'b0;
                for (int i = 0; i < BITS_PER_BYTE; i++)
                begin
                    pos = BIT_CNT_W'(order_lsb ? i : BITS_PER_BYTE - 1 - i);
                    assembled[pos] = line[BIT_CNT_W'(i)];
                    pin_clk = 1'b1;
                    push_pin_event(8'h00, 1'b0);
                    pin_clk = 1'b0;
                    if (i == BITS_PER_BYTE - 1)
                        push_pin_event(assembled, 1'b1);
                    else
                        push_pin_event(8'h00, 1'b0);
                end
            end
            KIND_CLK_HIGH:
            begin
                pin_clk = 1'b1;
                push_pin_event(8'h00, 1'b1);
            end
            KIND_CLK_LOW:
            begin
                pin_clk = 1'b0;
                push_pin_event(8'h00, 1'b1);
            end
            KIND_CLK_PULSE:
            begin
                pin_clk = 1'b1;
                push_pin_event(8'h00, 1'b0);
                pin_clk = 1'b0;
                push_pin_event(8'h00, 1'b1);
            end
            KIND_SDA_HIGH:
            begin
                pin_sda = 1'b1;
                push_pin_event(8'h00, 1'b1);
            end
            KIND_SDA_LOW:
            begin
                pin_sda = 1'b0;
                push_pin_event(8'h00, 1'b1);
            end
            KIND_READ_CLKD:
            begin
                pin_clk = 1'b1;
                push_pin_event(8'h00, 1'b0);
                pin_clk = 1'b0;
                push_pin_event({7'b0, line[0]}, 1'b1);
            end
            KIND_READ_BIT:
                push_pin_event({7'b0, line[0]}, 1'b1);
            default:
                ; // unused codes: no pin activity
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Prediction first, so a beat that could leave on the accept edge still finds its entry.
    always @(posedge clk)
    begin
        pin_event_t want;
        if (rst_n === 1'b1)
        begin
            if (in_valid && in_ready === 1'b1)
            begin
                predict_pin_events(kind, tx_byte, line_bits);
                if (golden_on)
                    pending_events[pending_events.size() - 1] = golden_ev;
            end
            if (out_valid === 1'b1 && out_ready)
            begin
                if (pending_events.size() == 0)
                begin
                    $display("%0t: unexpected pin event, expected none, actual %b%b%b rx=%0h last=%b",
                             $time, clk_level, sda_level, sda_drive, rx_value, last);
                    mismatches++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("clk_level", 8'(want.clk_pin), 8'(clk_level));
                    check_field("sda_level", 8'(want.sda), 8'(sda_level));
                    check_field("sda_drive", 8'(want.drive), 8'(sda_drive));
                    check_field("rx_value", want.rx, rx_value);
                    check_field("last", 8'(want.fin), 8'(last));
                end
            end
        end
    end

    // out_ready: random stall bursts between runs of varying length; held high while no_idle is set
    always @(posedge clk)
    begin
        if (no_idle === 1'b1)
            out_ready <= 1'b1;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if ($urandom_range(0, 2) == 0)
        begin
            out_ready <= 1'b0;
            hold_left <= $urandom_range(0, 13);
        end
        else
        begin
            out_ready <= 1'b1;
            hold_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                      : $urandom_range(0, 30);
        end
    end

    task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [7:0] tx,
                            input logic [7:0] line, input logic typed, input pin_event_t g);
        kind      <= k;
        tx_byte   <= tx;
        line_bits <= line;
        golden_on <= typed;
        golden_ev <= g;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    task automatic maybe_idle();
        if (!no_idle && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        @(posedge clk);
        if (idx == REG_LSB_FIRST)
            order_lsb = data[0];
    endtask

    function automatic logic [KIND_W-1:0] pick_kind(input bit edge_free);
        int r;
        r = $urandom_range(0, 99);
        if (edge_free)
        begin
            if (r < 30)      return KIND_SDA_HIGH;
            else if (r < 60) return KIND_SDA_LOW;
            else if (r < 90) return KIND_READ_BIT;
        end
        else
        begin
            if (r < 22)      return KIND_WRITE_BYTE;
            else if (r < 44) return KIND_READ_BYTE;
            else if (r < 52) return KIND_CLK_HIGH;
            else if (r < 60) return KIND_CLK_LOW;
            else if (r < 68) return KIND_CLK_PULSE;
            else if (r < 75) return KIND_SDA_HIGH;
            else if (r < 82) return KIND_SDA_LOW;
            else if (r < 88) return KIND_READ_CLKD;
            else if (r < 94) return KIND_READ_BIT;
        end
        return KIND_FIRST_UNUSED + 4'($urandom_range(0, 6));
    endfunction

    initial
    begin
        logic [KIND_W-1:0]     k;
        logic [CFG_DATA_W-1:0] lsb_word;
        int                    counted;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_LSB_FIRST;
        cfg_data  = '0;
        in_valid  = 1'b0;
        kind      = KIND_WRITE_BYTE;
        tx_byte   = '0;
        line_bits = '0;
        golden_on = 1'b0;
        golden_ev = NO_GOLDEN;
        no_idle   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[r])
        begin
            send_cmd(DIRECTED_ROWS[r].k, DIRECTED_ROWS[r].tx, DIRECTED_ROWS[r].line,
                     DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].golden);
            maybe_idle();
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // upper bits of the bit-order word are don't-care
            lsb_word    = 16'($urandom_range(0, 65535));
            lsb_word[0] = PHASE_LSB[ph][0];
            write_reg(REG_LSB_FIRST, lsb_word);
            write_reg(REG_TICK_PRESCALE, PHASE_PRESCALE[ph][CFG_DATA_W-1:0]);
            cfg_we <= 1'b0;
            if (ph == NUM_PHASES - 1)
                no_idle <= 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS[ph])
            begin
                // slowest prescaler: only commands that move no clock edge
                k = pick_kind(PHASE_PRESCALE[ph] > 3);
                send_cmd(k, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         1'b0, NO_GOLDEN);
                if (k <= KIND_READ_BIT)
                    counted++;
                maybe_idle();
            end
            drain();
        end

        if (pending_events.size() != 0)
        begin
            $display("%0t: %0d pin events expected, actual none", $time, pending_events.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
